// ===== src/decimal_scale_align_macros.svh =====
// assertion helpers for the decimal scale alignment block
`ifndef DECIMAL_SCALE_ALIGN_MACROS_SVH
`define DECIMAL_SCALE_ALIGN_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define DSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define DSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dsa_pkg.sv =====
package dsa_pkg;

	// field widths
	localparam int MANT_W  = 96;
	localparam int LOW_W   = 64;
	localparam int HIGH_W  = 32;
	localparam int SCALE_W = 5;

	// default largest decimal scale
	localparam int MAX_SCALE = 28;

	// decimal digit arithmetic
	localparam int RADIX      = 10;
	localparam int HALF_DIGIT = 5;
	localparam int REM_W      = 4;
	localparam int PROD_W     = MANT_W + REM_W;

	// long division by ten, several quotient bits per cycle
	localparam int DIGIT_BITS  = 8;
	localparam int DIGIT_STEPS = MANT_W / DIGIT_BITS;
	localparam int CNT_W       = $clog2(DIGIT_STEPS);

	// shared unit operations
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIG = 2'd1;
	localparam logic [1:0] OP_RND = 2'd2;

	typedef struct packed {
		logic [LOW_W-1:0]   mant_a_low;
		logic [HIGH_W-1:0]  mant_a_high;
		logic [SCALE_W-1:0] scale_a;
		logic [LOW_W-1:0]   mant_b_low;
		logic [HIGH_W-1:0]  mant_b_high;
		logic [SCALE_W-1:0] scale_b;
	} in_req_t;

	typedef struct packed {
		logic [LOW_W-1:0]   out_a_low;
		logic [HIGH_W-1:0]  out_a_high;
		logic [LOW_W-1:0]   out_b_low;
		logic [HIGH_W-1:0]  out_b_high;
		logic [SCALE_W-1:0] common_scale;
	} out_req_t;

	// sequencer outputs
	typedef struct packed {
		logic       busy;
		logic       in_ready;
		logic       load;
		logic [1:0] op;
		logic       first;
		logic       lo_we;
		logic       hi_dig;
		logic       hi_rnd;
		logic       fin;
	} ctrl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic sc_eq;
		logic ovf;
		logic out_free;
	} stat_t;

	// shared unit result
	typedef struct packed {
		logic [MANT_W-1:0] res;
		logic [REM_W-1:0]  rem;
		logic              ovf;
	} unit_res_t;

endpackage

// ===== src/dsa_step_unit.sv =====
// one step of decimal arithmetic on a 96-bit mantissa
module dsa_step_unit (
	input  logic [1:0]                     op,
	input  logic [dsa_pkg::MANT_W-1:0]     x,
	input  logic [dsa_pkg::REM_W-1:0]      rem_in,
	output dsa_pkg::unit_res_t             y
);

	logic [dsa_pkg::PROD_W-1:0]     prod;
	logic [dsa_pkg::REM_W-1:0]      r;
	logic [dsa_pkg::REM_W:0]        t;
	logic [dsa_pkg::DIGIT_BITS-1:0] q;
	logic                           inc;

	// times ten as 8x + 2x
	assign prod = ({{dsa_pkg::REM_W{1'b0}}, x} << 3) + ({{dsa_pkg::REM_W{1'b0}}, x} << 1);

	// restoring division of the top byte, remainder carried in
	always_comb begin
		r = rem_in;
		q = '0;
		t = '0;
		for (int i = dsa_pkg::DIGIT_BITS - 1; i >= 0; i--) begin
			t = {r, x[dsa_pkg::MANT_W - dsa_pkg::DIGIT_BITS + i]};
			if (t >= (dsa_pkg::REM_W + 1)'(dsa_pkg::RADIX)) begin
				q[i] = 1'b1;
				t    = t - (dsa_pkg::REM_W + 1)'(dsa_pkg::RADIX);
			end
			r = t[dsa_pkg::REM_W-1:0];
		end
	end

	// round half to even on the last remainder digit
	assign inc = (rem_in > dsa_pkg::REM_W'(dsa_pkg::HALF_DIGIT)) ||
		((rem_in == dsa_pkg::REM_W'(dsa_pkg::HALF_DIGIT)) && x[0]);

	always_comb begin
		y.res = x;
		y.rem = rem_in;
		y.ovf = 1'b0;
		case (op)
			dsa_pkg::OP_MUL: begin
				y.res = prod[dsa_pkg::MANT_W-1:0];
				y.ovf = |prod[dsa_pkg::PROD_W-1:dsa_pkg::MANT_W];
			end
			dsa_pkg::OP_DIG: begin
				y.res = {x[dsa_pkg::MANT_W-dsa_pkg::DIGIT_BITS-1:0], q};
				y.rem = r;
			end
			dsa_pkg::OP_RND: begin
				y.res = x + {{(dsa_pkg::MANT_W-1){1'b0}}, inc};
			end
			default: begin
				y.res = x;
			end
		endcase
	end

endmodule

// ===== src/dsa_ctrl.sv =====
// step sequencer: scale up, then divide down, then hand over the result
module dsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dsa_pkg::stat_t   stat,
	output dsa_pkg::ctrl_t   ctrl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                state_q, state_d;
	logic [dsa_pkg::CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		ctrl          = '0;
		ctrl.busy     = (state_q != ST_IDLE);
		ctrl.op       = dsa_pkg::OP_MUL;
		case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				ctrl.op = dsa_pkg::OP_MUL;
				if (stat.sc_eq || stat.ovf) begin
					state_d = ST_DIV;
					cnt_d   = '0;
				end else begin
					ctrl.lo_we = 1'b1;
				end
			end
			ST_DIV: begin
				ctrl.op    = dsa_pkg::OP_DIG;
				ctrl.first = (cnt_q == '0);
				if ((cnt_q == '0) && stat.sc_eq) begin
					state_d = ST_FIN;
				end else begin
					ctrl.hi_dig = 1'b1;
					if (cnt_q == dsa_pkg::CNT_W'(dsa_pkg::DIGIT_STEPS - 1)) begin
						cnt_d   = '0;
						state_d = ST_RND;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_RND: begin
				ctrl.op     = dsa_pkg::OP_RND;
				ctrl.hi_rnd = 1'b1;
				state_d     = ST_DIV;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					ctrl.fin = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== src/decimal_scale_align.sv =====
// Aligns two 96-bit unsigned decimal mantissas to one decimal scale. Input scales above
// MAX_SCALE are clamped to it. The operand with the smaller scale is multiplied by ten,
// one step per cycle, until the scales meet or the next step would overflow 96 bits; the
// other operand is then divided by ten, with round half to even on each dropped digit,
// until the scales meet. One request is worked at a time and in_ready is low meanwhile.
// Each divide is a long division, 8 quotient bits per cycle through the shared step unit,
// followed by a rounding step. The result sits in an output register, so a new request
// is taken while the last result waits.
`include "decimal_scale_align_macros.svh"

module decimal_scale_align #(
	parameter int MAX_SCALE = dsa_pkg::MAX_SCALE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dsa_pkg::in_req_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dsa_pkg::out_req_t  out_data
);

	dsa_pkg::ctrl_t     ctrl;
	dsa_pkg::stat_t     stat;
	dsa_pkg::unit_res_t ures;

	// lo: operand with the smaller scale (scaled up), hi: the larger one (divided down)
	logic [dsa_pkg::MANT_W-1:0]  lo_q, hi_q;
	logic [dsa_pkg::SCALE_W-1:0] sc_lo_q, sc_hi_q;
	logic                        swap_q;
	logic [dsa_pkg::REM_W-1:0]   rem_q;
	dsa_pkg::out_req_t           out_q;
	logic                        out_valid_q;

	// clamped input scales
	logic [dsa_pkg::SCALE_W-1:0] sa, sb;
	logic [dsa_pkg::MANT_W-1:0]  ma, mb;
	logic                        a_is_hi;

	// shared unit operand select
	logic [dsa_pkg::MANT_W-1:0]  unit_x;
	logic [dsa_pkg::REM_W-1:0]   unit_rem;

	assign sa = (in_data.scale_a > dsa_pkg::SCALE_W'(MAX_SCALE)) ?
		dsa_pkg::SCALE_W'(MAX_SCALE) : in_data.scale_a;
	assign sb = (in_data.scale_b > dsa_pkg::SCALE_W'(MAX_SCALE)) ?
		dsa_pkg::SCALE_W'(MAX_SCALE) : in_data.scale_b;
	assign ma = {in_data.mant_a_high, in_data.mant_a_low};
	assign mb = {in_data.mant_b_high, in_data.mant_b_low};
	assign a_is_hi = (sa > sb);

	// multiply steps work on lo, divide and round steps on hi
	assign unit_x   = (ctrl.op == dsa_pkg::OP_MUL) ? lo_q : hi_q;
	// the first digit of each division starts from a zero remainder
	assign unit_rem = ctrl.first ? '0 : rem_q;

	dsa_step_unit u_step (
		.op     (ctrl.op),
		.x      (unit_x),
		.rem_in (unit_rem),
		.y      (ures)
	);

	// status for the sequencer
	assign stat.sc_eq    = (sc_lo_q == sc_hi_q);
	assign stat.ovf      = ures.ovf;
	assign stat.out_free = !out_valid_q || out_ready;

	dsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			swap_q  <= a_is_hi;
			lo_q    <= a_is_hi ? mb : ma;
			hi_q    <= a_is_hi ? ma : mb;
			sc_lo_q <= a_is_hi ? sb : sa;
			sc_hi_q <= a_is_hi ? sa : sb;
		end
		if (ctrl.lo_we) begin
			lo_q    <= ures.res;
			sc_lo_q <= sc_lo_q + 1'b1;
		end
		if (ctrl.hi_dig) begin
			hi_q  <= ures.res;
			rem_q <= ures.rem;
		end
		if (ctrl.hi_rnd) begin
			hi_q    <= ures.res;
			sc_hi_q <= sc_hi_q - 1'b1;
		end
	end

	// output register, payload put back into a/b order
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			out_q.out_a_low    <= swap_q ? hi_q[dsa_pkg::LOW_W-1:0] : lo_q[dsa_pkg::LOW_W-1:0];
			out_q.out_a_high   <= swap_q ? hi_q[dsa_pkg::MANT_W-1:dsa_pkg::LOW_W] :
				lo_q[dsa_pkg::MANT_W-1:dsa_pkg::LOW_W];
			out_q.out_b_low    <= swap_q ? lo_q[dsa_pkg::LOW_W-1:0] : hi_q[dsa_pkg::LOW_W-1:0];
			out_q.out_b_high   <= swap_q ? lo_q[dsa_pkg::MANT_W-1:dsa_pkg::LOW_W] :
				hi_q[dsa_pkg::MANT_W-1:dsa_pkg::LOW_W];
			out_q.common_scale <= sc_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// scales stay ordered and in range while a request is being worked
	`DSA_ASSERT_NOW(a_scale_order, clk, arst_n, ctrl.busy && !$past(ctrl.load) && !ctrl.load, (sc_lo_q <= sc_hi_q) && (sc_hi_q <= dsa_pkg::SCALE_W'(MAX_SCALE)), "scale order broken")
	// a result leaves only once both scales agree
	`DSA_ASSERT_NOW(a_fin_equal, clk, arst_n, ctrl.fin, sc_lo_q == sc_hi_q, "result with unequal scales")
	// every rounding step drops the larger scale by one
	`DSA_ASSERT_NEXT(a_rnd_step, clk, arst_n, ctrl.hi_rnd, sc_hi_q == dsa_pkg::SCALE_W'($past(sc_hi_q) - 1'b1), "rounding did not lower scale")
	// a finished request always shows up at the output
	`DSA_ASSERT_NEXT(a_fin_valid, clk, arst_n, ctrl.fin, out_valid, "finished request not presented")

endmodule
